// ===== design/bba_pkg.sv =====
// Shared widths, codes and types of the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    localparam int BLK_W = 12;
    localparam int CNT_W = 13;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

    typedef struct packed {
        logic hit;
        logic last_word;
    } t_scan_flags;

endpackage

`default_nettype wire

// ===== design/bba_word_scan.sv =====
// Lowest free block search within one bitmap word, limited to the managed blocks.
`default_nettype none

module bba_word_scan
    import bba_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CW        = CNT_W
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CW-1:0]        i_base,
    input  logic [CW-1:0]        i_limit,
    output t_scan_flags          o_flags,
    output logic [WORD_BITS-1:0] o_onehot,
    output logic [CW-1:0]        o_block
);

    localparam int BI = $clog2(WORD_BITS);
    localparam logic [CW-1:0] WB_C = CW'(WORD_BITS);

    logic [CW-1:0]        left;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] cand;
    logic [BI-1:0]        idx;

    always_comb begin
        left = i_limit - i_base;
        if (left >= WB_C) begin
            mask = '1;
        end else begin
            mask = ~({WORD_BITS{1'b1}} << left[BI-1:0]);
        end
        cand     = ~i_word & mask;
        o_onehot = cand & (~cand + 1'b1);
        idx      = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (o_onehot[j]) begin
                idx = idx | BI'(j);
            end
        end
        o_flags.hit       = |cand;
        o_flags.last_word = ({1'b0, i_base} + (CW+1)'(WORD_BITS)) >= {1'b0, i_limit};
        o_block           = i_base + CW'(idx);
    end

endmodule

`default_nettype wire

// ===== design/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator: top level with the bitmap memory and sequencer.
//
// Requests arrive on the input channel (i_valid, o_stall) as an opcode and a
// block number; each request yields exactly one result beat on the output
// channel (o_valid, i_stall) carrying the granted block and a status.
// The block count register is written through i_cfg_valid / o_cfg_ready,
// which is always ready; write it only while no request is in flight.
// The used/free bits sit in one memory of MAP_WORDS words with a registered
// read, updated by read-modify-write. One request is handled at a time.
// Free, mark-used and unknown opcodes pass from acceptance through S_ADDR to
// S_EVAL, which loads their result. Allocate reads one word per cycle from
// word zero, scanning up to MAP_WORDS words (64 at the default size), and
// loads its result once a free block or the last word is found. The next
// request is accepted once the state is back in S_IDLE. A stalled result
// holds the block in S_EVAL until the output register frees up.
// After reset the memory is cleared one word per cycle with o_stall high;
// the block count returns to 4096.
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [BLK_W-1:0] i_block_number,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [BLK_W-1:0] o_allocated_block,
    output logic [ST_W-1:0]  o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_block_count
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LW        = $clog2(MAX_BLOCKS + 1);
    localparam int CW        = (LW > CNT_W) ? LW : CNT_W;
    localparam int BI        = $clog2(WORD_BITS);
    localparam int SH        = BLK_W + BI;
    localparam int RW        = SH + 1;
    localparam int PW        = BLK_W + RW;
    localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] WB_C    = CW'(WORD_BITS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_ADDR  = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [CNT_W-1:0]     r_block_count;
    logic [OP_W-1:0]      r_op;
    logic [BLK_W-1:0]     r_blk;
    logic [AW-1:0]        r_widx, n_widx;
    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_out_valid, n_out_valid;
    logic [BLK_W-1:0]     r_alloc, n_alloc;
    logic [ST_W-1:0]      r_status, n_status;

    logic                 in_accept;
    logic                 out_free;
    logic [CW-1:0]        limit;
    logic                 in_range;
    logic [PW-1:0]        prod;
    logic [AW-1:0]        q_word;
    logic [CW-1:0]        base;
    logic [CW-1:0]        rem;
    logic [WORD_BITS-1:0] bit_sel;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    t_scan_flags          scan;
    logic [WORD_BITS-1:0] scan_onehot;
    logic [CW-1:0]        scan_block;

    assign o_stall           = (r_state != S_IDLE);
    assign in_accept         = i_valid && !o_stall;
    assign o_valid           = r_out_valid;
    assign o_allocated_block = r_alloc;
    assign o_status          = r_status;
    assign o_cfg_ready       = 1'b1;
    assign out_free          = !r_out_valid || !i_stall;

    assign limit    = (CW'(r_block_count) > MAX_C) ? MAX_C : CW'(r_block_count);
    assign in_range = CW'(r_blk) < limit;
    assign prod     = PW'(r_blk) * PW'(RECIP_C);
    assign q_word   = AW'(prod >> SH);
    assign base     = CW'(r_widx) * WB_C;
    assign rem      = CW'(r_blk) - base;
    assign bit_sel  = WORD_BITS'(1) << rem[BI-1:0];

    bba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_scan (
        .i_word   (r_rd_data),
        .i_base   (base),
        .i_limit  (limit),
        .o_flags  (scan),
        .o_onehot (scan_onehot),
        .o_block  (scan_block)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_widx      = r_widx;
        n_out_valid = r_out_valid && i_stall;
        n_alloc     = r_alloc;
        n_status    = r_status;
        rd_en       = 1'b0;
        rd_addr     = r_widx;
        wr_en       = 1'b0;
        wr_addr     = r_widx;
        wr_data     = r_rd_data;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_ADDR;
                    n_widx  = '0;
                end
            end
            S_ADDR: begin
                n_state = S_EVAL;
                if (r_op == OP_ALLOC) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end else if ((r_op == OP_FREE || r_op == OP_MARK) && in_range) begin
                    rd_en   = 1'b1;
                    rd_addr = q_word;
                    n_widx  = q_word;
                end
            end
            S_EVAL: begin
                if (r_op == OP_ALLOC && !scan.hit && !scan.last_word) begin
                    rd_en   = 1'b1;
                    rd_addr = r_widx + 1'b1;
                    n_widx  = r_widx + 1'b1;
                end else if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_alloc     = '0;
                    n_status    = ST_OK;
                    case (r_op)
                        OP_ALLOC: begin
                            if (scan.hit) begin
                                wr_en   = 1'b1;
                                wr_data = r_rd_data | scan_onehot;
                                n_alloc = BLK_W'(scan_block);
                            end else begin
                                n_status = ST_EXHAUSTED;
                            end
                        end
                        OP_FREE, OP_MARK: begin
                            if (!in_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                wr_en = 1'b1;
                                if (r_op == OP_MARK) begin
                                    wr_data = r_rd_data | bit_sel;
                                end else begin
                                    wr_data = r_rd_data & ~bit_sel;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_block_count <= BLOCK_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_block_count <= i_block_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_opcode;
            r_blk <= i_block_number;
        end
        r_widx   <= n_widx;
        r_alloc  <= n_alloc;
        r_status <= n_status;
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_EXHAUSTED || o_status == ST_RANGE))
        else $error("Result beat carries an unknown status code.");

    a_block_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_allocated_block == '0))
        else $error("Failed request reports a nonzero block number.");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("Bitmap word read and written in the same cycle.");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !o_valid)
        else $error("Result beat produced while the bitmap is being cleared.");

endmodule

`default_nettype wire
